// ===== design/bekr_pkg.sv =====
// ----------------------------------------------------------------------------
// bekr_pkg
// Shared types and constants of the button edge and key repeat block.
// ----------------------------------------------------------------------------
package bekr_pkg;

  // number of buttons and field widths
  localparam int unsigned Buttons = 24;
  localparam int unsigned CntW    = 8;
  localparam int unsigned CfgIdxW = 2;

  // press counter saturation value
  localparam logic [CntW-1:0] PressMax = 8'hFF;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRepeatMask  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRepeatDelay = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeatSteps = 2'd2;

  // configuration reset values
  localparam logic [CntW-1:0] DelayRst = 8'd16;
  localparam logic [CntW-1:0] StepsRst = 8'd1;
  localparam logic [CntW-1:0] QuotRst  = 8'd16;

  // repeat timing shared by every lane
  typedef struct packed {
    logic [CntW-1:0] delay;
    logic [CntW-1:0] steps;
    logic [CntW-1:0] quot;
  } lane_cfg_t;

endpackage

// ===== design/bekr_div.sv =====
// ----------------------------------------------------------------------------
// bekr_div
// Restoring divider, one quotient bit per cycle, for the repeat step size.
// ----------------------------------------------------------------------------
module bekr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bekr_pkg::CntW-1:0] dividend_i,
  input  logic [bekr_pkg::CntW-1:0] divisor_i,
  output logic                      busy_o,
  output logic [bekr_pkg::CntW-1:0] quot_o
);

  logic                      busy_q, busy_d;
  logic [2:0]                cnt_q, cnt_d;
  logic [bekr_pkg::CntW:0]   rem_q, rem_d;
  logic [bekr_pkg::CntW-1:0] quo_q, quo_d;
  logic [bekr_pkg::CntW-1:0] div_q, div_d;
  logic [bekr_pkg::CntW-1:0] res_q, res_d;
  logic [bekr_pkg::CntW:0]   rem_sh;
  logic                      fits;

  // one shift and trial subtract
  assign rem_sh = {rem_q[bekr_pkg::CntW-1:0], quo_q[bekr_pkg::CntW-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd7;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quo_d = {quo_q[bekr_pkg::CntW-2:0], fits};
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        res_d  = {quo_q[bekr_pkg::CntW-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      res_q  <= bekr_pkg::QuotRst;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      res_q  <= res_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign quot_o = res_q;

endmodule

// ===== design/bekr_lane.sv =====
// ----------------------------------------------------------------------------
// bekr_lane
// Press counter and repeat step count of one button, with repeat firing.
// ----------------------------------------------------------------------------
module bekr_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                held_i,
  input  logic                mask_i,
  input  bekr_pkg::lane_cfg_t cfg_i,
  output logic                fire_o
);

  logic [bekr_pkg::CntW-1:0]   hold_q, hold_d;
  logic [bekr_pkg::CntW-1:0]   step_q, step_d;
  logic [bekr_pkg::CntW-1:0]   hold_a, step_a, step_c, thr;
  logic [2*bekr_pkg::CntW-1:0] prod;
  logic                        fire;

  // count frames held, clear on release
  assign hold_a = !held_i ? '0 :
                  (hold_q == bekr_pkg::PressMax) ? hold_q : hold_q + 8'd1;
  assign step_a = held_i ? step_q : '0;

  // clamp step and form the threshold modulo 256
  assign step_c = (step_a >= cfg_i.steps) ? cfg_i.steps - 8'd1 : step_a;
  assign prod   = {8'd0, step_c} * {8'd0, cfg_i.quot};
  assign thr    = cfg_i.delay - prod[bekr_pkg::CntW-1:0];
  assign fire   = mask_i && (hold_a >= thr);

  always_comb begin
    hold_d = hold_a;
    step_d = step_a;
    if (mask_i) begin
      step_d = fire ? step_c + 8'd1 : step_c;
      if (fire) begin
        hold_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      step_q <= '0;
    end else if (en_i) begin
      hold_q <= hold_d;
      step_q <= step_d;
    end
  end

  assign fire_o = fire;

endmodule

// ===== design/button_edge_and_key_repeat.sv =====
// ----------------------------------------------------------------------------
// button_edge_and_key_repeat
// Button edge masks and accelerating key repeat, one button word per frame.
// ----------------------------------------------------------------------------
// channel   | signals                                   | role
// switches  | switches_valid_i/ready_o, switches_i      | button word request in
// result    | out_valid_o/ready_i, held_o..repeat_res_o | edge and repeat masks out
// config    | cfg_we_i, cfg_idx_i, cfg_data_i           | register write, no wait
//
// One button word per cycle when not held off, through the input register, then
// the lane logic into the result register. A word enters the input register
// while a result waits only if that register is empty; once both hold a word,
// every cycle the result waits also holds off the input.
// A write to repeat_delay or repeat_steps runs the step quotient through the
// bit-serial divider: input is held off until the divider is done.
// Reset loads the register defaults and clears all counters.
module button_edge_and_key_repeat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          switches_valid_i,
  output logic                          switches_ready_o,
  input  logic [bekr_pkg::Buttons-1:0]  switches_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bekr_pkg::Buttons-1:0]  held_o,
  output logic [bekr_pkg::Buttons-1:0]  pressed_o,
  output logic [bekr_pkg::Buttons-1:0]  released_o,
  output logic [bekr_pkg::Buttons-1:0]  changed_o,
  output logic [bekr_pkg::Buttons-1:0]  repeat_res_o,
  input  logic                          cfg_we_i,
  input  logic [bekr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bekr_pkg::Buttons-1:0]  cfg_data_i
);

  logic [bekr_pkg::Buttons-1:0] mask_q;
  logic [bekr_pkg::CntW-1:0]    delay_q, steps_q, steps_eff, quot;
  logic                         div_start_q, div_busy, busy;
  bekr_pkg::lane_cfg_t          lane_cfg;

  logic                         in_valid_q, out_valid_q, advance, accept;
  logic [bekr_pkg::Buttons-1:0] sw_q, prev_q, fire;
  logic [bekr_pkg::Buttons-1:0] diff, press, rel;
  logic [bekr_pkg::Buttons-1:0] held_q, pressed_q, released_q, changed_q, rep_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      delay_q     <= bekr_pkg::DelayRst;
      steps_q     <= bekr_pkg::StepsRst;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bekr_pkg::CfgRepeatMask: begin
            mask_q <= cfg_data_i;
          end
          bekr_pkg::CfgRepeatDelay: begin
            delay_q     <= cfg_data_i[bekr_pkg::CntW-1:0];
            div_start_q <= 1'b1;
          end
          bekr_pkg::CfgRepeatSteps: begin
            steps_q     <= cfg_data_i[bekr_pkg::CntW-1:0];
            div_start_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // zero steps counts as one
  assign steps_eff = (steps_q == '0) ? 8'd1 : steps_q;

  // step quotient delay / steps
  bekr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (delay_q),
    .divisor_i  (steps_eff),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign busy           = div_start_q | div_busy;
  assign lane_cfg.delay = delay_q;
  assign lane_cfg.steps = steps_eff;
  assign lane_cfg.quot  = quot;

  // handshake between input register and result register
  assign advance          = in_valid_q && (!out_valid_q || out_ready_i);
  assign switches_ready_o = !busy && (!in_valid_q || advance);
  assign accept           = switches_valid_i && switches_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sw_q <= switches_i;
    end
  end

  // edge masks
  assign diff  = prev_q ^ sw_q;
  assign press = sw_q & diff;
  assign rel   = prev_q & diff;

  // per-button repeat lanes
  for (genvar i = 0; i < bekr_pkg::Buttons; i++) begin : g_lane
    bekr_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .held_i (sw_q[i]),
      .mask_i (mask_q[i]),
      .cfg_i  (lane_cfg),
      .fire_o (fire[i])
    );
  end

  // previous word and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        prev_q      <= sw_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      held_q     <= sw_q;
      pressed_q  <= press;
      released_q <= rel;
      changed_q  <= diff;
      rep_q      <= press | fire;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign held_o       = held_q;
  assign pressed_o    = pressed_q;
  assign released_o   = released_q;
  assign changed_o    = changed_q;
  assign repeat_res_o = rep_q;

  // no item taken while the quotient is being formed
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !div_busy && !div_start_q)
    else $error("input accepted while quotient in progress");

  // a timing write holds off input in the next cycle
  a_hold_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == bekr_pkg::CfgRepeatDelay ||
                 cfg_idx_i == bekr_pkg::CfgRepeatSteps) |=> !switches_ready_o)
    else $error("input ready right after timing write");

  // edges are disjoint and make up the change mask
  a_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pressed_o & released_o) == '0) &&
                    (changed_o == (pressed_o | released_o)))
    else $error("edge masks inconsistent");

  // a new press always shows in the repeat mask and is held
  a_press_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pressed_o & ~repeat_res_o) == '0) &&
                    ((pressed_o & ~held_o) == '0))
    else $error("press missing from repeat or held mask");

endmodule

// ===== verif/tb_button_edge_and_key_repeat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_edge_and_key_repeat
// Self-checking bench for the button edge and accelerating key repeat block.
// Button words go in through a valid/ready request channel. A frame-level
// predictor tracks the previous word, the per-button press counters and the
// repeat steps, and queues the expected edge and repeat masks. A checker
// compares every accepted result with the oldest expectation. Directed frames
// cover edges, repeat timing, acceleration, zero delay, zero steps and counter
// saturation. Random phases with random repeat settings and random stalls on
// both sides follow.
// ----------------------------------------------------------------------------
module tb_button_edge_and_key_repeat;

  typedef logic [bekr_pkg::Buttons-1:0] btn_word_t;
  typedef logic [bekr_pkg::CntW-1:0]    cnt_t;

  typedef struct packed {
    btn_word_t held;
    btn_word_t pressed;
    btn_word_t released;
    btn_word_t changed;
    btn_word_t repeat_res;
  } frame_masks_t;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned IdlePct    = 36;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         switches_valid_i;
  logic                         switches_ready_o;
  btn_word_t                    switches_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  btn_word_t                    held_o;
  btn_word_t                    pressed_o;
  btn_word_t                    released_o;
  btn_word_t                    changed_o;
  btn_word_t                    repeat_res_o;
  logic                         cfg_we_i;
  logic [bekr_pkg::CfgIdxW-1:0] cfg_idx_i;
  btn_word_t                    cfg_data_i;

  button_edge_and_key_repeat dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .switches_valid_i(switches_valid_i),
    .switches_ready_o(switches_ready_o),
    .switches_i      (switches_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .held_o          (held_o),
    .pressed_o       (pressed_o),
    .released_o      (released_o),
    .changed_o       (changed_o),
    .repeat_res_o    (repeat_res_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // expected masks waiting for their result
  frame_masks_t expected_masks_q[$];

  // predictor state and its copy of the repeat settings
  btn_word_t prev_switches_m;
  cnt_t      hold_cnt_m [bekr_pkg::Buttons];
  cnt_t      step_cnt_m [bekr_pkg::Buttons];
  btn_word_t rep_mask_m;
  cnt_t      rep_delay_m;
  cnt_t      rep_steps_m;
  cnt_t      step_quot_m;

  int unsigned error_cnt;
  int unsigned frames_sent;
  int unsigned results_seen;
  int unsigned repeat_events;
  int unsigned reg_writes;
  int unsigned hold_off_left;
  bit          no_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // frame predictor: edges, press counters, accelerating repeat
  function automatic frame_masks_t predict_frame(input btn_word_t now);
    frame_masks_t r;
    btn_word_t    diff;
    cnt_t         eff_steps;
    cnt_t         thr;
    int           i;
    diff         = prev_switches_m ^ now;
    r.held       = now;
    r.pressed    = now & diff;
    r.released   = prev_switches_m & diff;
    r.changed    = diff;
    r.repeat_res = r.pressed;
    eff_steps    = (rep_steps_m == '0) ? cnt_t'(1) : rep_steps_m;
    prev_switches_m = now;
    for (i = 0; i < bekr_pkg::Buttons; i++) begin
      if (now[i]) begin
        if (hold_cnt_m[i] != bekr_pkg::PressMax)
          hold_cnt_m[i] = hold_cnt_m[i] + cnt_t'(1);
      end else begin
        hold_cnt_m[i] = '0;
        step_cnt_m[i] = '0;
      end
    end
    for (i = 0; i < bekr_pkg::Buttons; i++) begin
      if (rep_mask_m[i]) begin
        if (step_cnt_m[i] >= eff_steps) step_cnt_m[i] = eff_steps - cnt_t'(1);
        thr = rep_delay_m - cnt_t'(step_cnt_m[i] * step_quot_m);
        if (hold_cnt_m[i] >= thr) begin
          hold_cnt_m[i]   = '0;
          step_cnt_m[i]   = step_cnt_m[i] + cnt_t'(1);
          r.repeat_res[i] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // random idle cycles before the next request
  function automatic int unsigned idle_gap();
    int unsigned n;
    n = 0;
    while (!no_idle && $urandom_range(99) < IdlePct) n++;
    return n;
  endfunction

  // offer one button word and record its expected masks once taken
  task automatic send_switches(input btn_word_t word);
    int unsigned gap;
    gap = idle_gap();
    @(negedge clk_i);
    repeat (gap) begin
      switches_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    switches_valid_i <= 1'b1;
    switches_i       <= word;
    @(posedge clk_i);
    while (!switches_ready_o) @(posedge clk_i);
    expected_masks_q.push_back(predict_frame(word));
    frames_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk_i);
    switches_valid_i <= 1'b0;
    while (expected_masks_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic [bekr_pkg::CfgIdxW-1:0] idx,
                           input btn_word_t data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      bekr_pkg::CfgRepeatMask:  rep_mask_m  = data;
      bekr_pkg::CfgRepeatDelay: rep_delay_m = data[bekr_pkg::CntW-1:0];
      bekr_pkg::CfgRepeatSteps: rep_steps_m = data[bekr_pkg::CntW-1:0];
      default: ;
    endcase
    step_quot_m = rep_delay_m / ((rep_steps_m == '0) ? cnt_t'(1) : rep_steps_m);
    reg_writes++;
  endtask

  task automatic set_repeat(input btn_word_t mask, input cnt_t delay, input cnt_t steps);
    wait_drained();
    write_reg(bekr_pkg::CfgRepeatMask, mask);
    write_reg(bekr_pkg::CfgRepeatDelay, btn_word_t'(delay));
    write_reg(bekr_pkg::CfgRepeatSteps, btn_word_t'(steps));
  endtask

  // random words: mostly sticky holds with a few flips, some pure noise
  function automatic btn_word_t next_word(input btn_word_t cur);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return cur ^ btn_word_t'($urandom & $urandom & $urandom & $urandom);
    else if (pick < 88) return '0;
    else return btn_word_t'($urandom);
  endfunction

  // receiver: random stalls plus a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_ready_i   <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic check_field(input string name, input btn_word_t exp_v,
                             input btn_word_t act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %06h actual %06h", name, exp_v, act_v);
      error_cnt++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    frame_masks_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_masks_q.size() == 0) begin
        $error("result with no frame outstanding: held %06h repeat %06h",
               held_o, repeat_res_o);
        error_cnt++;
      end else begin
        e = expected_masks_q.pop_front();
        check_field("held", e.held, held_o);
        check_field("pressed", e.pressed, pressed_o);
        check_field("released", e.released, released_o);
        check_field("changed", e.changed, changed_o);
        check_field("repeat_res", e.repeat_res, repeat_res_o);
        repeat_events += $countones(e.repeat_res);
      end
    end
  end

  // watchdog on cycles with no request taken on either side
  initial begin
    int unsigned stall_cnt;
    stall_cnt = 0;
    while (stall_cnt < StallLimit) begin
      @(posedge clk_i);
      if ((switches_valid_i && switches_ready_o) || (out_valid_o && out_ready_i))
        stall_cnt = 0;
      else
        stall_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // edges on every bit with the reset settings (no repeat buttons)
  task automatic test_edges();
    send_switches(24'hFFFFFF);
    send_switches(24'hFFFFFF);
    send_switches(24'h000000);
    send_switches(24'hAAAAAA);
    send_switches(24'h555555);
    send_switches(24'h800001);
    send_switches(24'h000000);
  endtask

  // first repeat after the delay, with a single repeat step
  task automatic test_repeat_timing();
    set_repeat(24'hFFFFFF, 8'd3, 8'd1);
    repeat (5) send_switches(24'h800001);
    send_switches(24'h000000);
  endtask

  // repeat intervals shrink by delay/steps per step
  task automatic test_acceleration();
    set_repeat(24'h000401, 8'd4, 8'd4);
    repeat (11) send_switches(24'h000401);
    send_switches(24'h000000);
  endtask

  // zero delay fires every frame, held or not
  task automatic test_zero_delay();
    set_repeat(24'h0F00F0, 8'd0, 8'd2);
    send_switches(24'h000000);
    send_switches(24'h0000F0);
  endtask

  // zero steps behaves as one step
  task automatic test_zero_steps();
    set_repeat(24'hFFFFFF, 8'd2, 8'd0);
    repeat (3) send_switches(24'h00F00F);
  endtask

  // press counter stops at 255 while its button is not a repeat button
  task automatic test_saturation();
    int unsigned k;
    btn_word_t   noise;
    set_repeat(24'h000000, 8'd255, 8'd1);
    no_idle = 1'b1;
    noise   = '0;
    for (k = 0; k < 262; k++) begin
      noise = next_word(noise);
      send_switches(noise | 24'h000080);
    end
    no_idle = 1'b0;
    wait_drained();
    write_reg(bekr_pkg::CfgRepeatMask, 24'h000080);
    repeat (4) send_switches(24'h000080);
  endtask

  // receiver held off while the sender keeps offering
  task automatic test_backpressure();
    int unsigned k;
    btn_word_t   w;
    set_repeat(24'hFFFFFF, 8'd2, 8'd2);
    w             = '0;
    hold_off_left = 80;
    for (k = 0; k < 24; k++) begin
      w = next_word(w);
      send_switches(w);
    end
    // sender pauses until every result is back, then resumes
    wait_drained();
    for (k = 0; k < 10; k++) begin
      w = next_word(w);
      send_switches(w);
    end
  endtask

  // random phases over a spread of repeat settings
  task automatic test_random_phases();
    int unsigned p;
    int unsigned k;
    btn_word_t   w;
    w = '0;
    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_repeat(24'hFFFFFF, 8'd3, 8'd1);
        1: set_repeat(btn_word_t'($urandom), 8'd0, 8'd3);
        2: set_repeat(24'hFFFFFF, 8'd255, 8'd255);
        3: set_repeat(btn_word_t'($urandom), cnt_t'($urandom_range(1, 20)),
                      cnt_t'($urandom_range(1, 8)));
        4: set_repeat(btn_word_t'($urandom), cnt_t'($urandom_range(1, 12)), 8'd0);
        default: set_repeat(24'h000000, 8'd1, 8'd1);
      endcase
      for (k = 0; k < 50; k++) begin
        w = next_word(w);
        send_switches(w);
      end
    end
  endtask

  // main sequence
  initial begin
    int i;
    rst_ni           = 1'b0;
    switches_valid_i = 1'b0;
    switches_i       = '0;
    out_ready_i      = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = bekr_pkg::CfgRepeatMask;
    cfg_data_i       = '0;
    error_cnt        = 0;
    frames_sent      = 0;
    results_seen     = 0;
    repeat_events    = 0;
    reg_writes       = 0;
    hold_off_left    = 0;
    no_idle          = 1'b0;
    prev_switches_m  = '0;
    rep_mask_m       = '0;
    rep_delay_m      = bekr_pkg::DelayRst;
    rep_steps_m      = bekr_pkg::StepsRst;
    step_quot_m      = bekr_pkg::QuotRst;
    for (i = 0; i < bekr_pkg::Buttons; i++) begin
      hold_cnt_m[i] = '0;
      step_cnt_m[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_edges();
    test_repeat_timing();
    test_acceleration();
    test_zero_delay();
    test_zero_steps();
    test_saturation();
    test_backpressure();
    test_random_phases();

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d frames and %0d results, %0d repeat bits, %0d register writes",
             frames_sent, results_seen, repeat_events, reg_writes);
    $display("settings included zero delay, zero steps, 255/255 and a saturated counter");
    if (error_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== button_edge_and_key_repeat.f =====
design/bekr_pkg.sv
design/bekr_div.sv
design/bekr_lane.sv
design/button_edge_and_key_repeat.sv
verif/tb_button_edge_and_key_repeat.sv
